FILE: design/phs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package phs_pkg;

	// Operation codes of an input item
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_MOVE = 1'b1;

	// Motor action codes of a result item
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_ABS  = 2'd1;
	localparam logic [1:0] ACT_STOP = 2'd2;
	localparam logic [1:0] ACT_REL  = 2'd3;

	// Preset codes; the last code selects nothing
	localparam logic [1:0] PRESET_REST = 2'd0;
	localparam logic [1:0] PRESET_ONE  = 2'd1;
	localparam logic [1:0] PRESET_TWO  = 2'd2;
	localparam logic [1:0] PRESET_NONE = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_PRESET_REST   = 3'd0;
	localparam logic [2:0] REG_PRESET_ONE    = 3'd1;
	localparam logic [2:0] REG_PRESET_TWO    = 3'd2;
	localparam logic [2:0] REG_MOVE_SPEED    = 3'd3;
	localparam logic [2:0] REG_DRIFT_LIMIT   = 3'd4;
	localparam logic [2:0] REG_STUCK_TIMEOUT = 3'd5;
	localparam logic [2:0] REG_SENSOR_TIMEOUT = 3'd6;
	localparam logic [2:0] REG_NUDGE_AMOUNT  = 3'd7;

	// Reset values of the configuration registers
	localparam logic [31:0] RST_PRESET_REST    = 32'sd18000;
	localparam logic [31:0] RST_PRESET_ONE     = -32'sd93000;
	localparam logic [31:0] RST_PRESET_TWO     = -32'sd140500;
	localparam logic [9:0]  RST_MOVE_SPEED     = 10'd100;
	localparam logic [30:0] RST_DRIFT_LIMIT    = 31'd500;
	localparam logic [31:0] RST_STUCK_TIMEOUT  = 32'd1500;
	localparam logic [31:0] RST_SENSOR_TIMEOUT = 32'd10000;
	localparam logic [30:0] RST_NUDGE_AMOUNT   = 31'd1000;

	// Motor counts as arrived within this many centidegrees of the target
	localparam logic signed [32:0] ARRIVE_WINDOW = 33'sd500;

	typedef struct packed {
		logic [31:0] preset_rest;
		logic [31:0] preset_one;
		logic [31:0] preset_two;
		logic [9:0]  move_speed;
		logic [30:0] drift_limit;
		logic [31:0] stuck_timeout_ms;
		logic [31:0] quiet_timeout_ms;
		logic [30:0] nudge_amount;
	} phs_cfg_t;

	typedef struct packed {
		logic        opcode;
		logic [1:0]  preset_select;
		logic [31:0] now_ms;
		logic [31:0] motor_angle;
		logic [31:0] sensor_raw;
		logic        sensor_error;
	} phs_item_t;

	typedef struct packed {
		logic [1:0]  motor_action;
		logic [31:0] motor_amount;
		logic [9:0]  motor_speed;
		logic [1:0]  current_preset;
		logic        is_holding;
	} phs_result_t;

	typedef struct packed {
		logic [1:0]  active_preset;
		logic [31:0] move_start;
		logic        holding;
		logic [31:0] hold_reference;
		logic [31:0] last_sensor_value;
		logic        seen_sensor;
		logic [31:0] quiet_since;
		logic [31:0] last_nudge_time;
	} phs_state_t;

	// Target angle of a preset; any code past the second preset maps to it
	function automatic logic [31:0] target_of(input phs_cfg_t cfg, input logic [1:0] p);
		logic [31:0] t;
		case (p)
			PRESET_REST: t = cfg.preset_rest;
			PRESET_ONE:  t = cfg.preset_one;
			default:     t = cfg.preset_two;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: design/position_hold_supervisor_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Position hold supervisor: takes one item (tick or move command) per clock while the
// output is not stalled and gives exactly one result item for each. An item sits in the
// input register and moves to the result register once that register is free; one pass
// of compare and subtract logic against the configuration and the supervisor state
// produces its result, and the result register holds it while the next item is already
// accepted; sustained rate is one item per cycle, set by the single state update per item.
// Configuration registers are to be written through the write port only while no item is
// in flight; the user must keep to this, as the block itself does not enforce it.
module position_hold_supervisor_unit import phs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        opcode,
	input  wire logic [1:0]  preset_select,
	input  wire logic [31:0] now_ms,
	input  wire logic [31:0] motor_angle,
	input  wire logic [31:0] sensor_raw,
	input  wire logic        sensor_error,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [1:0]  motor_action,
	output      logic [31:0] motor_amount,
	output      logic [9:0]  motor_speed,
	output      logic [1:0]  current_preset,
	output      logic        is_holding
);

	phs_cfg_t    cfg;
	phs_item_t   item_s1;
	logic        valid_s1;
	phs_state_t  state_q;
	phs_state_t  state_nxt;
	phs_result_t res_nxt;
	phs_result_t res_q;
	logic        out_valid_q;
	logic        advance;

	phs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	phs_step u_step (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg),
		.res  (res_nxt),
		.nxt  (state_nxt)
	);

	// Move the staged item into the result register when that register frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{opcode:        opcode,
			             preset_select: preset_select,
			             now_ms:        now_ms,
			             motor_angle:   motor_angle,
			             sensor_raw:    sensor_raw,
			             sensor_error:  sensor_error};
		end
	end

	// Supervisor state advances with each item that reaches the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign motor_action   = res_q.motor_action;
	assign motor_amount   = res_q.motor_amount;
	assign motor_speed    = res_q.motor_speed;
	assign current_preset = res_q.current_preset;
	assign is_holding     = res_q.is_holding;

	// A stop always leaves the supervisor holding
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.motor_action == ACT_STOP) |-> res_q.is_holding)
		else $error("stop result without hold");

	// An absolute move always leaves the supervisor moving
	a_move_releases: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.motor_action == ACT_ABS) |-> !res_q.is_holding)
		else $error("absolute move result while holding");

	// No action and stop carry neither amount nor speed
	a_quiet_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((res_q.motor_action == ACT_NONE) || (res_q.motor_action == ACT_STOP))
		|-> (res_q.motor_amount == 32'd0) && (res_q.motor_speed == 10'd0))
		else $error("payload on a result without motion");

	// The active preset never takes the unused code
	a_preset_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.active_preset != PRESET_NONE)
		else $error("active preset holds the unused code");

	// A staged item reaches the result register when it is free
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("staged item not moved to the result register");

endmodule

`default_nettype wire

FILE: design/phs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module phs_cfg import phs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output phs_cfg_t         cfg
);

	phs_cfg_t cfg_q;

	// Write one register per enabled cycle, truncating to its width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preset_rest       <= RST_PRESET_REST;
			cfg_q.preset_one        <= RST_PRESET_ONE;
			cfg_q.preset_two        <= RST_PRESET_TWO;
			cfg_q.move_speed        <= RST_MOVE_SPEED;
			cfg_q.drift_limit       <= RST_DRIFT_LIMIT;
			cfg_q.stuck_timeout_ms  <= RST_STUCK_TIMEOUT;
			cfg_q.quiet_timeout_ms  <= RST_SENSOR_TIMEOUT;
			cfg_q.nudge_amount      <= RST_NUDGE_AMOUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESET_REST:    cfg_q.preset_rest       <= cfg_data;
				REG_PRESET_ONE:     cfg_q.preset_one        <= cfg_data;
				REG_PRESET_TWO:     cfg_q.preset_two        <= cfg_data;
				REG_MOVE_SPEED:     cfg_q.move_speed        <= cfg_data[9:0];
				REG_DRIFT_LIMIT:    cfg_q.drift_limit       <= cfg_data[30:0];
				REG_STUCK_TIMEOUT:  cfg_q.stuck_timeout_ms  <= cfg_data;
				REG_SENSOR_TIMEOUT: cfg_q.quiet_timeout_ms  <= cfg_data;
				REG_NUDGE_AMOUNT:   cfg_q.nudge_amount      <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: design/phs_step.sv
`timescale 1ns / 1ps
`default_nettype none

module phs_step import phs_pkg::*; (
	input  phs_item_t   item,
	input  phs_state_t  st,
	input  phs_cfg_t    cfg,
	output phs_result_t res,
	output phs_state_t  nxt
);

	logic [31:0]        tgt;
	logic [31:0]        sel_tgt;
	logic signed [32:0] arr_diff;
	logic signed [32:0] drift_diff;
	logic signed [32:0] drift_lim;
	logic               arrived;
	logic               stuck;
	logic               drifted;
	logic               alive;
	logic [31:0]        quiet_nxt;
	logic               dead;
	logic               nudge_due;
	logic [31:0]        nudge_step;

	// Targets of the active preset and of the selected preset
	assign tgt     = target_of(cfg, st.active_preset);
	assign sel_tgt = target_of(cfg, item.preset_select);

	// Arrival window and stuck timeout while moving
	assign arr_diff = $signed({tgt[31], tgt}) - $signed({item.motor_angle[31], item.motor_angle});
	assign arrived  = (arr_diff < ARRIVE_WINDOW) && (arr_diff > -ARRIVE_WINDOW);
	assign stuck    = (item.now_ms - st.move_start) > cfg.stuck_timeout_ms;

	// Drift of the sensor against the hold reference
	assign drift_diff = $signed({item.sensor_raw[31], item.sensor_raw})
		- $signed({st.hold_reference[31], st.hold_reference});
	assign drift_lim  = $signed({2'b00, cfg.drift_limit});
	assign drifted    = (drift_diff > drift_lim) || (drift_diff < -drift_lim);

	// Sensor liveness: a fresh, valid reading keeps it alive
	assign alive     = !item.sensor_error
		&& (!st.seen_sensor || (item.sensor_raw != st.last_sensor_value));
	assign quiet_nxt = (st.quiet_since == 32'd0) ? item.now_ms : st.quiet_since;
	assign dead      = !alive && ((item.now_ms - quiet_nxt) > cfg.quiet_timeout_ms);
	assign nudge_due = (item.now_ms - st.last_nudge_time) > cfg.quiet_timeout_ms;

	// Blind nudge toward the sign of the target
	assign nudge_step = tgt[31] ? (32'd0 - {1'b0, cfg.nudge_amount}) : {1'b0, cfg.nudge_amount};

	// Step the supervisor for one item
	always_comb begin
		nxt              = st;
		res.motor_action = ACT_NONE;
		res.motor_amount = '0;
		res.motor_speed  = '0;
		if (item.opcode == OP_MOVE) begin
			if (item.preset_select != PRESET_NONE) begin
				nxt.active_preset = item.preset_select;
				nxt.move_start    = item.now_ms;
				nxt.holding       = 1'b0;
				res.motor_action  = ACT_ABS;
				res.motor_amount  = sel_tgt;
				res.motor_speed   = cfg.move_speed;
			end
		end else if (!st.holding) begin
			if (arrived || stuck) begin
				res.motor_action    = ACT_STOP;
				nxt.holding         = 1'b1;
				nxt.hold_reference  = item.sensor_raw;
				nxt.quiet_since     = '0;
				nxt.last_nudge_time = '0;
			end
		end else if (st.active_preset != PRESET_REST) begin
			if (alive) begin
				nxt.last_sensor_value = item.sensor_raw;
				nxt.seen_sensor       = 1'b1;
				nxt.quiet_since       = '0;
			end else begin
				nxt.quiet_since = quiet_nxt;
			end
			if (dead) begin
				if (nudge_due) begin
					res.motor_action    = ACT_REL;
					res.motor_amount    = nudge_step;
					res.motor_speed     = cfg.move_speed;
					nxt.last_nudge_time = item.now_ms;
				end
			end else begin
				nxt.last_nudge_time = '0;
				if (drifted) begin
					nxt.move_start   = item.now_ms;
					nxt.holding      = 1'b0;
					res.motor_action = ACT_ABS;
					res.motor_amount = tgt;
					res.motor_speed  = cfg.move_speed;
				end
			end
		end
		res.current_preset = nxt.active_preset;
		res.is_holding     = nxt.holding;
	end

endmodule

`default_nettype wire

FILE: tb/position_hold_supervisor_unit_tb.sv
`timescale 1ns / 1ps

module position_hold_supervisor_unit_tb;
	import phs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam longint ARRIVAL_BAND = 500;

	// Sensor behavior drawn for the hold stretch of one move episode
	typedef enum int {
		SENSE_STEADY,
		SENSE_DRIFT,
		SENSE_FROZEN,
		SENSE_FAULTY,
		SENSE_MIXED
	} sense_mode_t;

	// Tracks supervisor state and settings, and holds the results still owed
	class hold_tracker;
		phs_cfg_t cfg;
		phs_state_t st;
		phs_result_t pending_results[$];
		int unsigned mismatches;
		int unsigned results_checked;
		int unsigned action_count[4];

		function new();
			cfg.preset_rest = RST_PRESET_REST;
			cfg.preset_one = RST_PRESET_ONE;
			cfg.preset_two = RST_PRESET_TWO;
			cfg.move_speed = RST_MOVE_SPEED;
			cfg.drift_limit = RST_DRIFT_LIMIT;
			cfg.stuck_timeout_ms = RST_STUCK_TIMEOUT;
			cfg.quiet_timeout_ms = RST_SENSOR_TIMEOUT;
			cfg.nudge_amount = RST_NUDGE_AMOUNT;
			st = '0;
			mismatches = 0;
			results_checked = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_PRESET_REST: cfg.preset_rest = data;
				REG_PRESET_ONE: cfg.preset_one = data;
				REG_PRESET_TWO: cfg.preset_two = data;
				REG_MOVE_SPEED: cfg.move_speed = data[9:0];
				REG_DRIFT_LIMIT: cfg.drift_limit = data[30:0];
				REG_STUCK_TIMEOUT: cfg.stuck_timeout_ms = data;
				REG_SENSOR_TIMEOUT: cfg.quiet_timeout_ms = data;
				REG_NUDGE_AMOUNT: cfg.nudge_amount = data[30:0];
				default: ;
			endcase
		endfunction

		function longint preset_angle(logic [1:0] p);
			logic [31:0] t;
			case (p)
				PRESET_REST: t = cfg.preset_rest;
				PRESET_ONE: t = cfg.preset_one;
				default: t = cfg.preset_two;
			endcase
			return longint'($signed(t));
		endfunction

		function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		function void note_item(phs_item_t it);
			phs_result_t r;
			longint tgt;
			logic [31:0] elapsed;
			logic [31:0] step;
			bit dead;
			r = '0;
			dead = 1'b0;
			if (it.opcode == OP_MOVE) begin
				// Start a move toward a real preset; the spare code does nothing
				if (it.preset_select != PRESET_NONE) begin
					st.active_preset = it.preset_select;
					st.move_start = it.now_ms;
					st.holding = 1'b0;
					r.motor_action = ACT_ABS;
					r.motor_amount = preset_angle(it.preset_select);
					r.motor_speed = cfg.move_speed;
				end
			end else if (!st.holding) begin
				// Settle on arrival, or once the move has run too long
				tgt = preset_angle(st.active_preset);
				elapsed = it.now_ms - st.move_start;
				if (mag(tgt - longint'($signed(it.motor_angle))) < ARRIVAL_BAND ||
						elapsed > cfg.stuck_timeout_ms) begin
					r.motor_action = ACT_STOP;
					st.holding = 1'b1;
					st.hold_reference = it.sensor_raw;
					st.quiet_since = '0;
					st.last_nudge_time = '0;
				end
			end else if (st.active_preset != PRESET_REST) begin
				tgt = preset_angle(st.active_preset);
				// A fresh good reading keeps the sensor alive; anything else runs the quiet time
				if (!it.sensor_error &&
						(!st.seen_sensor || it.sensor_raw != st.last_sensor_value)) begin
					st.last_sensor_value = it.sensor_raw;
					st.seen_sensor = 1'b1;
					st.quiet_since = '0;
				end else begin
					if (st.quiet_since == '0)
						st.quiet_since = it.now_ms;
					elapsed = it.now_ms - st.quiet_since;
					dead = elapsed > cfg.quiet_timeout_ms;
				end
				if (dead) begin
					// Nudge blindly toward the sign of the target, once per period
					elapsed = it.now_ms - st.last_nudge_time;
					if (elapsed > cfg.quiet_timeout_ms) begin
						step = {1'b0, cfg.nudge_amount};
						r.motor_action = ACT_REL;
						r.motor_amount = (tgt < 0) ? -step : step;
						r.motor_speed = cfg.move_speed;
						st.last_nudge_time = it.now_ms;
					end
				end else begin
					// Reissue the move when the pivot drifted too far
					st.last_nudge_time = '0;
					if (mag(longint'($signed(it.sensor_raw)) - longint'($signed(st.hold_reference)))
							> longint'({1'b0, cfg.drift_limit})) begin
						st.move_start = it.now_ms;
						st.holding = 1'b0;
						r.motor_action = ACT_ABS;
						r.motor_amount = tgt;
						r.motor_speed = cfg.move_speed;
					end
				end
			end
			r.current_preset = st.active_preset;
			r.is_holding = st.holding;
			pending_results.push_back(r);
			action_count[r.motor_action]++;
		endfunction

		function void check_result(phs_result_t got);
			phs_result_t want;
			if (pending_results.size() == 0) begin
				$error("result with no item waiting: action %0d amount %0d",
					got.motor_action, $signed(got.motor_amount));
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			if (got.motor_action !== want.motor_action) begin
				$error("motor_action expected %0d got %0d", want.motor_action, got.motor_action);
				mismatches++;
			end
			if (got.motor_amount !== want.motor_amount) begin
				$error("motor_amount expected %0d got %0d",
					$signed(want.motor_amount), $signed(got.motor_amount));
				mismatches++;
			end
			if (got.motor_speed !== want.motor_speed) begin
				$error("motor_speed expected %0d got %0d", want.motor_speed, got.motor_speed);
				mismatches++;
			end
			if (got.current_preset !== want.current_preset) begin
				$error("current_preset expected %0d got %0d",
					want.current_preset, got.current_preset);
				mismatches++;
			end
			if (got.is_holding !== want.is_holding) begin
				$error("is_holding expected %0d got %0d", want.is_holding, got.is_holding);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic opcode;
	logic [1:0] preset_select;
	logic [31:0] now_ms;
	logic [31:0] motor_angle;
	logic [31:0] sensor_raw;
	logic sensor_error;
	logic out_valid;
	logic out_ready;
	logic [1:0] motor_action;
	logic [31:0] motor_amount;
	logic [9:0] motor_speed;
	logic [1:0] current_preset;
	logic is_holding;

	hold_tracker tracker;
	logic [31:0] clock_ms;
	bit burst_mode;
	bit hold_off_req;
	int idle_cycles;
	int items_sent;
	int settings_used;

	position_hold_supervisor_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.preset_select(preset_select),
		.now_ms(now_ms),
		.motor_angle(motor_angle),
		.sensor_raw(sensor_raw),
		.sensor_error(sensor_error),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.motor_action(motor_action),
		.motor_amount(motor_amount),
		.motor_speed(motor_speed),
		.current_preset(current_preset),
		.is_holding(is_holding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Sample both channels mid-cycle: note items about to be taken, check results
	always @(negedge clk) begin : sample_channels
		phs_item_t it;
		phs_result_t got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && in_ready) begin
				it.opcode = opcode;
				it.preset_select = preset_select;
				it.now_ms = now_ms;
				it.motor_angle = motor_angle;
				it.sensor_raw = sensor_raw;
				it.sensor_error = sensor_error;
				tracker.note_item(it);
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				got.motor_action = motor_action;
				got.motor_amount = motor_amount;
				got.motor_speed = motor_speed;
				got.current_preset = current_preset;
				got.is_holding = is_holding;
				tracker.check_result(got);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// End the run when no handshake happens for too long
	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("position_hold_supervisor_unit_tb NOT OK");
		$finish;
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			stall = burst_mode ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
		end
	end

	// Offer one item after a random gap; return at the edge that takes it
	task automatic offer_item(input phs_item_t it);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= it.opcode;
		preset_select <= it.preset_select;
		now_ms <= it.now_ms;
		motor_angle <= it.motor_angle;
		sensor_raw <= it.sensor_raw;
		sensor_error <= it.sensor_error;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic send_tick(input logic [31:0] motor, input logic [31:0] sens, input logic err);
		phs_item_t it;
		it.opcode = OP_TICK;
		it.preset_select = $urandom_range(0, 3);
		it.now_ms = clock_ms;
		it.motor_angle = motor;
		it.sensor_raw = sens;
		it.sensor_error = err;
		offer_item(it);
	endtask

	task automatic send_move(input logic [1:0] sel);
		phs_item_t it;
		it.opcode = OP_MOVE;
		it.preset_select = sel;
		it.now_ms = clock_ms;
		it.motor_angle = $urandom();
		it.sensor_raw = $urandom();
		it.sensor_error = $urandom_range(0, 1);
		offer_item(it);
	endtask

	// Drop valid and wait until every owed result has come out
	task automatic settle_block();
		in_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	task automatic program_regs(input logic [31:0] rest, input logic [31:0] one,
			input logic [31:0] two, input logic [31:0] speed, input logic [31:0] drift,
			input logic [31:0] stuck, input logic [31:0] quiet, input logic [31:0] nudge);
		write_reg(REG_PRESET_REST, rest);
		write_reg(REG_PRESET_ONE, one);
		write_reg(REG_PRESET_TWO, two);
		write_reg(REG_MOVE_SPEED, speed);
		write_reg(REG_DRIFT_LIMIT, drift);
		write_reg(REG_STUCK_TIMEOUT, stuck);
		write_reg(REG_SENSOR_TIMEOUT, quiet);
		write_reg(REG_NUDGE_AMOUNT, nudge);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic program_random_regs();
		program_regs($urandom_range(0, 400000) - 200000, $urandom_range(0, 400000) - 200000,
			$urandom_range(0, 400000) - 200000, $urandom_range(0, 600),
			$urandom_range(0, 3000), $urandom_range(0, 5000), $urandom_range(0, 20000),
			$urandom_range(0, 5000));
	endtask

	// Mostly move episodes (move, approach, settle, hold), some plain noise
	task automatic run_random_phase(input int n_items);
		phs_item_t it;
		int start;
		int pick;
		int off;
		int dlim;
		logic [1:0] sel;
		logic [31:0] tgt;
		logic [31:0] ref_val;
		logic [31:0] sens;
		logic [31:0] delta;
		logic [31:0] slice;
		logic err;
		sense_mode_t mode;
		sense_mode_t kind;
		start = items_sent;
		while (items_sent - start < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				it.opcode = $urandom_range(0, 1);
				it.preset_select = $urandom_range(0, 3);
				it.now_ms = $urandom_range(0, 1) ? clock_ms : $urandom();
				it.motor_angle = $urandom();
				it.sensor_raw = $urandom();
				it.sensor_error = $urandom_range(0, 1);
				offer_item(it);
			end else begin
				if (pick < 18)
					clock_ms = $urandom();
				else if (pick < 20)
					clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
				pick = $urandom_range(0, 99);
				sel = (pick < 20) ? PRESET_REST : (pick < 58) ? PRESET_ONE :
					(pick < 95) ? PRESET_TWO : PRESET_NONE;
				clock_ms += $urandom_range(0, 300);
				send_move(sel);
				tgt = tracker.preset_angle(tracker.st.active_preset);
				// Approach: motor still outside the arrival band
				repeat ($urandom_range(0, 3)) begin
					off = int'($urandom_range(500, 100000));
					if ($urandom_range(0, 1))
						off = -off;
					clock_ms += $urandom_range(0, 400);
					send_tick(tgt + off, $urandom(), $urandom_range(0, 1));
				end
				// Settle: either arrive or run out the stuck timeout
				ref_val = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 20000) - 10000;
				if ($urandom_range(0, 1)) begin
					clock_ms += $urandom_range(0, 200);
					send_tick(tgt + (int'($urandom_range(0, 998)) - 499), ref_val, 1'b0);
				end else begin
					clock_ms += tracker.cfg.stuck_timeout_ms + $urandom_range(0, 2);
					send_tick(tgt + 32'd100000, ref_val, $urandom_range(0, 1));
				end
				// Hold: exercise the sensor watch with one behavior per episode
				mode = sense_mode_t'($urandom_range(0, 4));
				sens = ref_val;
				slice = (tracker.cfg.quiet_timeout_ms >> 1) + 32'd1;
				dlim = (tracker.cfg.drift_limit > 31'd1000) ? 1000 : int'(tracker.cfg.drift_limit);
				repeat ($urandom_range(2, 14)) begin
					kind = (mode == SENSE_MIXED) ? sense_mode_t'($urandom_range(0, 3)) : mode;
					err = 1'b0;
					case (kind)
						SENSE_STEADY: begin
							sens = ref_val + (int'($urandom_range(0, 2 * dlim)) - dlim);
						end
						SENSE_DRIFT: begin
							delta = {1'b0, tracker.cfg.drift_limit} + $urandom_range(0, 2);
							sens = $urandom_range(0, 1) ? ref_val - delta : ref_val + delta;
						end
						SENSE_FROZEN: begin
							err = ($urandom_range(0, 9) == 0);
						end
						default: begin
							err = ($urandom_range(0, 4) != 0);
							if (err)
								sens = $urandom();
						end
					endcase
					if (kind >= SENSE_FROZEN && $urandom_range(0, 19) == 0)
						clock_ms = '0;
					else
						clock_ms += $urandom_range(0, slice);
					send_tick($urandom(), sens, err);
				end
			end
		end
	endtask

	initial begin
		int directed_items;
		tracker = new();
		clock_ms = '0;
		burst_mode = 1'b0;
		hold_off_req = 1'b0;
		idle_cycles = 0;
		items_sent = 0;
		settings_used = 1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_TICK;
		preset_select = PRESET_REST;
		now_ms = '0;
		motor_angle = '0;
		sensor_raw = '0;
		sensor_error = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on reset settings
		send_tick(32'd0, 32'd0, 1'b0);
		send_move(PRESET_NONE);
		clock_ms = 32'd100;
		send_move(PRESET_REST);
		clock_ms = 32'd200;
		send_tick(32'd18500, 32'd0, 1'b0);
		send_tick(32'd17501, 32'd123, 1'b0);
		send_tick(32'd0, 32'd999, 1'b0);
		clock_ms = 32'd1000;
		send_move(PRESET_ONE);
		clock_ms = 32'd2501;
		send_tick(32'd0, 32'd5000, 1'b0);
		// quiet time starting at time zero keeps the alive marker
		clock_ms = 32'd0;
		send_tick(32'd0, 32'd5000, 1'b0);
		send_tick(32'd0, 32'd5000, 1'b0);
		clock_ms = 32'd5000;
		send_tick(32'd0, 32'd5000, 1'b0);
		clock_ms = 32'd15001;
		send_tick(32'd0, 32'd5000, 1'b0);
		clock_ms = 32'd20000;
		send_tick(32'd0, 32'd5000, 1'b0);
		clock_ms = 32'd25002;
		send_tick(32'd0, 32'd5000, 1'b0);
		clock_ms = 32'd26000;
		send_tick(32'd0, 32'd777, 1'b1);
		clock_ms = 32'd27000;
		send_tick(32'd0, 32'd5600, 1'b0);
		send_tick(-32'sd93000, -32'sd7, 1'b0);
		send_tick(32'd0, 32'd493, 1'b0);
		// erroring but not yet dead sensor still feeds the drift check
		clock_ms = 32'd27100;
		send_tick(32'd0, 32'd2000, 1'b1);
		send_tick(-32'sd92501, 32'h7FFF_FFFF, 1'b0);
		send_tick(32'd0, 32'h8000_0000, 1'b0);
		clock_ms = 32'hFFFF_FFFF;
		send_tick(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		clock_ms = 32'hFFFF_FF00;
		send_move(PRESET_TWO);
		clock_ms = 32'h0000_0700;
		send_tick(32'h7FFF_FFFF, 32'd0, 1'b0);
		send_tick(32'd0, 32'd1, 1'b0);
		directed_items = items_sent;
		settle_block();

		// Extreme settings, both ends
		program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd600, 32'd0, 32'd0, 32'd0,
			32'h7FFF_FFFF);
		run_random_phase(250);
		settle_block();
		program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		run_random_phase(200);
		settle_block();

		// Moderate random settings; one phase with a long output hold-off
		program_random_regs();
		hold_off_req = 1'b1;
		run_random_phase(300);
		settle_block();
		program_random_regs();
		burst_mode = 1'b1;
		run_random_phase(250);
		burst_mode = 1'b0;
		settle_block();
		program_random_regs();
		run_random_phase(275);
		settle_block();
		program_regs(RST_PRESET_REST, RST_PRESET_ONE, RST_PRESET_TWO, RST_MOVE_SPEED,
			RST_DRIFT_LIMIT, RST_STUCK_TIMEOUT, RST_SENSOR_TIMEOUT, RST_NUDGE_AMOUNT);
		run_random_phase(250);
		settle_block();
		repeat (10) @(posedge clk);

		$display("ran %0d items (%0d directed) under %0d register settings, %0d results checked",
			items_sent, directed_items, settings_used, tracker.results_checked);
		$display("expected actions: %0d none, %0d absolute, %0d stop, %0d relative nudge",
			tracker.action_count[ACT_NONE], tracker.action_count[ACT_ABS],
			tracker.action_count[ACT_STOP], tracker.action_count[ACT_REL]);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
			$display("position_hold_supervisor_unit_tb OK");
		end else begin
			$display("position_hold_supervisor_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
